// ===== rtl/cah_pkg.sv =====
`timescale 1ns / 1ps

package cah_pkg;

	// Histogram geometry.
	localparam int MAX_ENERGY_BINS = 256;
	localparam int ANGLE_BINS      = 100;
	localparam int MAX_HITS        = 100;
	localparam int HIST_DEPTH      = MAX_ENERGY_BINS * ANGLE_BINS;
	localparam int HIST_AW         = $clog2(HIST_DEPTH);

	// Cosine bin search: even multiples of the half bin on each side of zero.
	localparam int HALF_BINS  = ANGLE_BINS / 2;
	localparam int SCAN_STEPS = HALF_BINS - 1;
	localparam int SCAN_W     = $clog2(SCAN_STEPS + 1);

	// Width of the squared cosine products.
	localparam int WIDE_W = 114;

	// Configuration register indexes and reset values.
	localparam logic CFG_BIN_WIDTH = 1'b0;
	localparam logic CFG_BINS_USED = 1'b1;
	localparam logic [23:0] BIN_WIDTH_RESET = 24'd1024;
	localparam logic [8:0]  BINS_USED_RESET = 9'd175;

	// Input commands.
	localparam logic [1:0] CMD_HIT  = 2'd0;
	localparam logic [1:0] CMD_SEP  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// Result status codes.
	localparam logic [2:0] STAT_FILLED    = 3'd0;
	localparam logic [2:0] STAT_FEW_HITS  = 3'd1;
	localparam logic [2:0] STAT_ZERO_DIST = 3'd2;
	localparam logic [2:0] STAT_ENERGY    = 3'd3;
	localparam logic [2:0] STAT_READ      = 3'd4;

	// One result item.
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  energy_bin;
		logic [6:0]  angle_bin;
		logic [31:0] count;
	} result_t;

endpackage

// ===== rtl/compton_angle_histogrammer.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   cmd, hit_energy, pos_x/y/z, read bins
// out       output     out_valid / out_ready status, energy_bin, angle_bin, count
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A separator with two or more hits uses the shared 29x29 multiplier, a decision state
// and, unless rejected there, the cosine bin scan and the read and write states of
// the counter read-modify-write; then the output state. A read uses the read, write
// and output states. After reset a clearing pass writes zero to all 25600 counters,
// one per cycle, while no input is taken. Hits are taken while a result waits at the
// output; a finished separator or read holds until the output register is free.

module compton_angle_histogrammer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [23:0]        hit_energy,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic [7:0]         read_energy_bin,
	input  logic [6:0]         read_angle_bin,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [7:0]         energy_bin,
	output logic [6:0]         angle_bin,
	output logic [31:0]        count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data
);
	import cah_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_RD     = 3'd5;
	localparam logic [2:0] ST_WR     = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	// Multiplier steps.
	localparam logic [4:0] OP_PXX = 5'd0;
	localparam logic [4:0] OP_PYY = 5'd1;
	localparam logic [4:0] OP_PZZ = 5'd2;
	localparam logic [4:0] OP_DXX = 5'd3;
	localparam logic [4:0] OP_DYY = 5'd4;
	localparam logic [4:0] OP_DZZ = 5'd5;
	localparam logic [4:0] OP_SX  = 5'd6;
	localparam logic [4:0] OP_SY  = 5'd7;
	localparam logic [4:0] OP_SZ  = 5'd8;
	localparam logic [4:0] OP_PLL = 5'd9;
	localparam logic [4:0] OP_PLH = 5'd10;
	localparam logic [4:0] OP_PHL = 5'd11;
	localparam logic [4:0] OP_PHH = 5'd12;
	localparam logic [4:0] OP_RLL = 5'd13;
	localparam logic [4:0] OP_RLH = 5'd14;
	localparam logic [4:0] OP_RHL = 5'd15;
	localparam logic [4:0] OP_RHH = 5'd16;

	logic [2:0] state_q;

	// Configuration and photon registers.
	logic [23:0] bin_width_q;
	logic [8:0]  bins_used_q;
	logic [6:0]  hit_count_q;
	logic [23:0] first_energy_q;
	logic signed [23:0] fx_q, fy_q, fz_q;
	logic signed [23:0] sx_q, sy_q, sz_q;

	// Arithmetic state.
	logic [4:0] op_q;
	logic       phase_q;
	logic signed [28:0] mul_a, mul_b;
	logic signed [57:0] prod_s1;
	logic [49:0] n1_q, n2_q;
	logic signed [50:0] s_q;
	logic [55:0] as_q;
	logic [WIDE_W-1:0] p_q, r_q, u_q, v_q;
	logic [SCAN_W-1:0] scan_cnt_q;

	// Energy divider.
	logic [23:0] div_rem_q, div_quo_q;
	logic [4:0]  div_cnt_q;
	logic [24:0] div_trial;

	// Histogram memory.
	logic [31:0] hist_mem [HIST_DEPTH];
	logic [HIST_AW-1:0] addr_q, clr_cnt_q;
	logic [31:0] mem_rdata_q;
	logic        mem_re, mem_we;
	logic [HIST_AW-1:0] mem_waddr;
	logic [31:0] mem_wdata;
	logic        is_read_q, rd_inrange_q;

	result_t res_q, out_q;
	logic    out_valid_q;

	logic in_xfer;
	logic signed [24:0] dx, dy, dz;
	logic [8:0]  bins_clamped;
	logic [50:0] abs_s;
	logic        scan_go;
	logic [6:0]  angle_found;
	logic [31:0] count_inc;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;

	assign dx = {sx_q[23], sx_q} - {fx_q[23], fx_q};
	assign dy = {sy_q[23], sy_q} - {fy_q[23], fy_q};
	assign dz = {sz_q[23], sz_q} - {fz_q[23], fz_q};

	assign bins_clamped = (bins_used_q > 9'(MAX_ENERGY_BINS)) ?
		9'(MAX_ENERGY_BINS) : bins_used_q;
	assign abs_s = s_q[50] ? -s_q : s_q;

	// The scan continues while the edge lies on the near side of the cosine.
	assign scan_go = (s_q[50] ? (u_q < r_q) : (u_q <= r_q)) &&
		(scan_cnt_q < SCAN_W'(SCAN_STEPS));
	assign angle_found = s_q[50] ? 7'(SCAN_STEPS) - 7'(scan_cnt_q) :
		7'(HALF_BINS) + 7'(scan_cnt_q);

	assign count_inc = (mem_rdata_q == 32'hFFFF_FFFF) ? mem_rdata_q : mem_rdata_q + 32'd1;
	assign div_trial = {div_rem_q, div_quo_q[23]} - {1'b0, bin_width_q};

	// Multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_PXX: begin mul_a = 29'(fx_q); mul_b = 29'(fx_q); end
			OP_PYY: begin mul_a = 29'(fy_q); mul_b = 29'(fy_q); end
			OP_PZZ: begin mul_a = 29'(fz_q); mul_b = 29'(fz_q); end
			OP_DXX: begin mul_a = 29'(dx); mul_b = 29'(dx); end
			OP_DYY: begin mul_a = 29'(dy); mul_b = 29'(dy); end
			OP_DZZ: begin mul_a = 29'(dz); mul_b = 29'(dz); end
			OP_SX:  begin mul_a = 29'(dx); mul_b = 29'(fx_q); end
			OP_SY:  begin mul_a = 29'(dy); mul_b = 29'(fy_q); end
			OP_SZ:  begin mul_a = 29'(dz); mul_b = 29'(fz_q); end
			OP_PLL: begin mul_a = {1'b0, n1_q[27:0]}; mul_b = {1'b0, n2_q[27:0]}; end
			OP_PLH: begin mul_a = {1'b0, n1_q[27:0]}; mul_b = {7'd0, n2_q[49:28]}; end
			OP_PHL: begin mul_a = {7'd0, n1_q[49:28]}; mul_b = {1'b0, n2_q[27:0]}; end
			OP_PHH: begin mul_a = {7'd0, n1_q[49:28]}; mul_b = {7'd0, n2_q[49:28]}; end
			OP_RLL: begin mul_a = {1'b0, as_q[27:0]}; mul_b = {1'b0, as_q[27:0]}; end
			OP_RLH: begin mul_a = {1'b0, as_q[27:0]}; mul_b = {1'b0, as_q[55:28]}; end
			OP_RHL: begin mul_a = {1'b0, as_q[55:28]}; mul_b = {1'b0, as_q[27:0]}; end
			OP_RHH: begin mul_a = {1'b0, as_q[55:28]}; mul_b = {1'b0, as_q[55:28]}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Shared multiplier with a registered product.
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// Memory port control: clearing pass, then read-modify-write.
	always_comb begin
		mem_re    = (state_q == ST_RD);
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = count_inc;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (state_q == ST_WR && !is_read_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= hist_mem[addr_q];
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= BIN_WIDTH_RESET;
			bins_used_q <= BINS_USED_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_BIN_WIDTH) begin
				bin_width_q <= cfg_data;
			end else begin
				bins_used_q <= cfg_data[8:0];
			end
		end
	end

	// Energy divider, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (in_xfer && cmd == CMD_SEP && hit_count_q >= 7'd2) begin
			div_cnt_q <= 5'd24;
			div_rem_q <= '0;
			div_quo_q <= first_energy_q;
		end else if (div_cnt_q != 5'd0) begin
			div_cnt_q <= div_cnt_q - 5'd1;
			if (!div_trial[24]) begin
				div_rem_q <= div_trial[23:0];
				div_quo_q <= {div_quo_q[22:0], 1'b1};
			end else begin
				div_rem_q <= {div_rem_q[22:0], div_quo_q[23]};
				div_quo_q <= {div_quo_q[22:0], 1'b0};
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign energy_bin = out_q.energy_bin;
	assign angle_bin  = out_q.angle_bin;
	assign count      = out_q.count;

	// Main sequencer and photon state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_cnt_q      <= '0;
			hit_count_q    <= '0;
			first_energy_q <= '0;
			fx_q <= '0; fy_q <= '0; fz_q <= '0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
			op_q       <= '0;
			phase_q    <= 1'b0;
			scan_cnt_q <= '0;
			is_read_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == HIST_AW'(HIST_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						case (cmd)
							CMD_HIT: begin
								if (hit_count_q < 7'(MAX_HITS)) begin
									if (hit_count_q == 7'd0) begin
										first_energy_q <= hit_energy;
										fx_q <= pos_x; fy_q <= pos_y; fz_q <= pos_z;
									end else if (hit_count_q == 7'd1) begin
										sx_q <= pos_x; sy_q <= pos_y; sz_q <= pos_z;
									end
									hit_count_q <= hit_count_q + 7'd1;
								end
							end
							CMD_SEP: begin
								hit_count_q <= '0;
								is_read_q   <= 1'b0;
								if (hit_count_q < 7'd2) begin
									state_q <= ST_OUT;
								end else begin
									op_q    <= OP_PXX;
									phase_q <= 1'b0;
									state_q <= ST_MUL;
								end
							end
							CMD_READ: begin
								is_read_q <= 1'b1;
								state_q   <= ST_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						op_q <= op_q + 5'd1;
						if (op_q == OP_RHH) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (n1_q == '0 || n2_q == '0) begin
						state_q <= ST_OUT;
					end else if (bin_width_q == '0 || div_quo_q >= 24'(bins_clamped)) begin
						state_q <= ST_OUT;
					end else begin
						scan_cnt_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Dot products, wide products and the cosine edge scan.
	always_ff @(posedge clk) begin
		if (in_xfer && cmd == CMD_SEP) begin
			n1_q <= '0;
			n2_q <= '0;
			s_q  <= '0;
			p_q  <= '0;
			r_q  <= '0;
		end else if (state_q == ST_MUL && !phase_q && op_q == OP_PLL) begin
			as_q <= 56'(abs_s[48:0]) * 56'(ANGLE_BINS);
		end else if (state_q == ST_MUL && phase_q) begin
			if (op_q <= OP_PZZ) begin
				n1_q <= n1_q + prod_s1[49:0];
			end else if (op_q <= OP_DZZ) begin
				n2_q <= n2_q + prod_s1[49:0];
			end else if (op_q <= OP_SZ) begin
				s_q <= s_q + prod_s1[50:0];
			end else if (op_q == OP_PLL) begin
				p_q <= p_q + {56'd0, prod_s1};
			end else if (op_q == OP_PLH || op_q == OP_PHL) begin
				p_q <= p_q + ({56'd0, prod_s1} << 28);
			end else if (op_q == OP_PHH) begin
				p_q <= p_q + ({56'd0, prod_s1} << 56);
			end else if (op_q == OP_RLL) begin
				r_q <= r_q + {56'd0, prod_s1};
			end else if (op_q == OP_RLH || op_q == OP_RHL) begin
				r_q <= r_q + ({56'd0, prod_s1} << 28);
			end else begin
				r_q <= r_q + ({56'd0, prod_s1} << 56);
			end
		end
		// Start the scan at the first edge pair: u holds a^2*P and v holds a*P.
		if (state_q == ST_DECIDE) begin
			u_q <= p_q << 2;
			v_q <= p_q << 1;
		end else if (state_q == ST_SCAN && scan_go) begin
			u_q <= u_q + (v_q << 2) + (p_q << 2);
			v_q <= v_q + (p_q << 1);
		end
	end

	// Result assembly and counter address.
	always_ff @(posedge clk) begin
		if (in_xfer && cmd == CMD_SEP) begin
			res_q.status     <= STAT_FEW_HITS;
			res_q.energy_bin <= '0;
			res_q.angle_bin  <= '0;
			res_q.count      <= '0;
		end else if (in_xfer && cmd == CMD_READ) begin
			res_q.status     <= STAT_READ;
			res_q.energy_bin <= read_energy_bin;
			res_q.angle_bin  <= read_angle_bin;
			addr_q           <= HIST_AW'(read_energy_bin) * HIST_AW'(ANGLE_BINS) +
				HIST_AW'(read_angle_bin);
			rd_inrange_q     <= (read_angle_bin < 7'(ANGLE_BINS));
		end else if (state_q == ST_DECIDE) begin
			if (n1_q == '0 || n2_q == '0) begin
				res_q.status <= STAT_ZERO_DIST;
			end else if (bin_width_q == '0 || div_quo_q >= 24'(bins_clamped)) begin
				res_q.status <= STAT_ENERGY;
			end
		end else if (state_q == ST_SCAN && !scan_go) begin
			res_q.status     <= STAT_FILLED;
			res_q.energy_bin <= div_quo_q[7:0];
			res_q.angle_bin  <= angle_found;
			addr_q           <= HIST_AW'(div_quo_q[7:0]) * HIST_AW'(ANGLE_BINS) +
				HIST_AW'(angle_found);
		end else if (state_q == ST_WR) begin
			if (is_read_q) begin
				res_q.count <= rd_inrange_q ? mem_rdata_q : 32'd0;
			end else begin
				res_q.count <= count_inc;
			end
		end
	end

	// The divider has finished before the energy bin is checked.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> (div_cnt_q == 5'd0))
		else $error("energy divider still busy at decision");

	// A counter write follows the read of the same address.
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR && !is_read_q) |-> ($past(state_q) == ST_RD && $stable(addr_q)))
		else $error("counter write without matching read");

	// The edge scan never runs past the last cosine edge.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_cnt_q <= SCAN_W'(SCAN_STEPS)))
		else $error("cosine scan out of range");

	// A filled counter is never zero.
	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_FILLED) |-> (count != 32'd0))
		else $error("filled counter reads zero");

endmodule

// ===== tb/sv/compton_angle_histogrammer_tb.sv =====
`timescale 1ns / 1ps

module compton_angle_histogrammer_tb;
	import cah_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES = 3000;
	localparam int PHASE_ITEMS = 65;

	// Scoreboard: keeps a copy of the photon state, the registers and the
	// histogram, and queues the result each accepted separator or read should cause.
	class histogram_scoreboard;
		int unsigned bin_width = BIN_WIDTH_RESET;
		int unsigned bins_used = BINS_USED_RESET;
		int unsigned hits;
		logic [23:0] first_energy;
		longint first_pos[3];
		longint second_pos[3];
		int unsigned hist[int];
		result_t wanted_q[$];
		int errors;

		function void set_reg(logic idx, logic [23:0] data);
			if (idx == CFG_BIN_WIDTH) begin
				bin_width = data;
			end else begin
				bins_used = data[8:0];
			end
		endfunction

		function int unsigned counter_at(int idx);
			if (hist.exists(idx)) begin
				return hist[idx];
			end
			return 0;
		endfunction

		// True when the lower edge of cosine bin j lies at or below s/sqrt(n1*n2).
		function bit cos_above_edge(int j, longint unsigned n1, longint unsigned n2,
			longint s);
			longint t;
			longint unsigned at, as_;
			logic [127:0] lhs, rhs;
			t = 2 * j - ANGLE_BINS;
			if (t <= 0 && s >= 0) begin
				return 1;
			end
			if (t >= 0 && s < 0) begin
				return 0;
			end
			at = (t < 0) ? -t : t;
			as_ = ((s < 0) ? -s : s) * ANGLE_BINS;
			lhs = 128'(at * at * n1) * 128'(n2);
			rhs = 128'(as_) * 128'(as_);
			return (t > 0) ? (lhs <= rhs) : (lhs >= rhs);
		endfunction

		function result_t close_photon();
			result_t r;
			longint unsigned n1, n2, used, ebin;
			longint s, p, d;
			int jb, idx;
			r = '0;
			n1 = 0;
			n2 = 0;
			s = 0;
			jb = 0;
			if (hits < 2) begin
				r.status = STAT_FEW_HITS;
				return r;
			end
			for (int i = 0; i < 3; i++) begin
				p = first_pos[i];
				d = second_pos[i] - p;
				n1 += p * p;
				n2 += d * d;
				s += d * p;
			end
			if (n1 == 0 || n2 == 0) begin
				r.status = STAT_ZERO_DIST;
				return r;
			end
			used = (bins_used > MAX_ENERGY_BINS) ? MAX_ENERGY_BINS : bins_used;
			if (bin_width == 0) begin
				r.status = STAT_ENERGY;
				return r;
			end
			ebin = first_energy / bin_width;
			if (ebin >= used) begin
				r.status = STAT_ENERGY;
				return r;
			end
			for (int j = 1; j < ANGLE_BINS; j++) begin
				if (!cos_above_edge(j, n1, n2, s)) break;
				jb = j;
			end
			idx = int'(ebin) * ANGLE_BINS + jb;
			if (counter_at(idx) != 32'hFFFF_FFFF) begin
				hist[idx] = counter_at(idx) + 1;
			end
			r.status = STAT_FILLED;
			r.energy_bin = ebin[7:0];
			r.angle_bin = jb[6:0];
			r.count = hist[idx];
			return r;
		endfunction

		function void note_input(logic [1:0] c, logic [23:0] e, logic signed [23:0] x,
			logic signed [23:0] y, logic signed [23:0] z, logic [7:0] reb, logic [6:0] rab);
			result_t r;
			r = '0;
			case (c)
				CMD_HIT: begin
					if (hits < MAX_HITS) begin
						if (hits == 0) begin
							first_energy = e;
							first_pos[0] = x;
							first_pos[1] = y;
							first_pos[2] = z;
						end else if (hits == 1) begin
							second_pos[0] = x;
							second_pos[1] = y;
							second_pos[2] = z;
						end
						hits++;
					end
				end
				CMD_SEP: begin
					wanted_q.push_back(close_photon());
					hits = 0;
				end
				CMD_READ: begin
					r.status = STAT_READ;
					r.energy_bin = reb;
					r.angle_bin = rab;
					if (rab < ANGLE_BINS) begin
						r.count = counter_at(int'(reb) * ANGLE_BINS + rab);
					end
					wanted_q.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check(result_t got);
			result_t w;
			if (wanted_q.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("Unexpected result transfer: status %0d bin %0d/%0d count %0d",
						got.status, got.energy_bin, got.angle_bin, got.count);
				end
				return;
			end
			w = wanted_q.pop_front();
			if (got.status !== w.status || got.energy_bin !== w.energy_bin ||
				got.angle_bin !== w.angle_bin || got.count !== w.count) begin
				errors++;
				if (errors <= 10) begin
					$display("Mismatch: expected status %0d bin %0d/%0d count %0d, got status %0d bin %0d/%0d count %0d",
						w.status, w.energy_bin, w.angle_bin, w.count,
						got.status, got.energy_bin, got.angle_bin, got.count);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_ready;
	logic [1:0] cmd;
	logic [23:0] hit_energy;
	logic signed [23:0] pos_x, pos_y, pos_z;
	logic [7:0] read_energy_bin;
	logic [6:0] read_angle_bin;
	logic out_valid, out_ready;
	logic [2:0] status;
	logic [7:0] energy_bin;
	logic [6:0] angle_bin;
	logic [31:0] count;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [23:0] cfg_data;

	histogram_scoreboard sb = new();
	int send_idle_pct;
	int recv_stall_pct;
	int hold_reqs;
	int hold_seen;
	int hold_left;
	int cycles;
	int sent;

	compton_angle_histogrammer dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		in_valid <= 1'b0;
		cmd <= CMD_HIT;
		hit_energy <= '0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		read_energy_bin <= '0;
		read_angle_bin <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_BIN_WIDTH;
		cfg_data <= '0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: check every transfer, stall at random or for a long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				sb.check('{status, energy_bin, angle_bin, count});
			end
			if (hold_seen != hold_reqs) begin
				hold_seen <= hold_reqs;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one input transfer, with random idle cycles in front of it.
	task automatic send(logic [1:0] c, logic [23:0] e, logic signed [23:0] x,
		logic signed [23:0] y, logic signed [23:0] z, logic [7:0] reb, logic [6:0] rab);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		hit_energy <= e;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		read_energy_bin <= reb;
		read_angle_bin <= rab;
		do @(posedge clk); while (!in_ready);
		sb.note_input(c, e, x, y, z, reb, rab);
		if (c != CMD_UNUSED) sent++;
	endtask

	task automatic send_hit(logic [23:0] e, logic signed [23:0] x, logic signed [23:0] y,
		logic signed [23:0] z);
		send(CMD_HIT, e, x, y, z, $urandom, $urandom);
	endtask

	task automatic send_sep();
		send(CMD_SEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic send_read(logic [7:0] reb, logic [6:0] rab);
		send(CMD_READ, $urandom, $urandom, $urandom, $urandom, reb, rab);
	endtask

	// Let every expected result arrive, then let a photon in flight finish.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.wanted_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(128) - 64;
			7: return 24'sh7FFFFF;
			8: return -24'sh800000;
			9: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Energy that mostly lands in a used bin of the current setting.
	function automatic logic [23:0] rand_energy();
		longint unsigned used, e;
		used = (sb.bins_used > MAX_ENERGY_BINS) ? MAX_ENERGY_BINS : sb.bins_used;
		if (used == 0 || sb.bin_width == 0 || $urandom_range(9) == 0) begin
			return $urandom;
		end
		e = longint'($urandom_range(used - 1)) * sb.bin_width +
			$urandom_range(sb.bin_width - 1);
		return (e > 24'hFFFFFF) ? 24'($urandom) : e[23:0];
	endfunction

	task automatic random_photon();
		int r, nh;
		logic signed [23:0] fx, fy, fz;
		r = $urandom_range(99);
		nh = (r < 80) ? 2 : (r < 90) ? 3 : (r < 95) ? 1 : $urandom_range(4, 8);
		fx = rand_coord();
		fy = rand_coord();
		fz = rand_coord();
		for (int h = 0; h < nh; h++) begin
			if (h == 1 && $urandom_range(19) == 0) begin
				send_hit(rand_energy(), fx, fy, fz);
			end else if (h == 0) begin
				send_hit(rand_energy(), fx, fy, fz);
			end else begin
				send_hit(rand_energy(), rand_coord(), rand_coord(), rand_coord());
			end
		end
		send_sep();
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			random_photon();
		end else if (r < 85) begin
			if ($urandom_range(1)) begin
				send_read($urandom_range(3), $urandom_range(ANGLE_BINS - 1));
			end else begin
				send_read($urandom, $urandom);
			end
		end else if (r < 90) begin
			send_sep();
		end else if (r < 95) begin
			send_hit(rand_energy(), rand_coord(), rand_coord(), rand_coord());
		end else begin
			send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		logic [23:0] widths[4];
		logic [23:0] used_set[4];
		int idle_set[4];
		int stall_set[4];
		int target;
		widths = '{24'd1024, 24'd1, 24'hFFFFFF, 24'd300};
		used_set = '{24'd175, 24'd256, 24'd511, 24'd1};
		idle_set = '{0, 72, 0, 28};
		stall_set = '{0, 0, 72, 28};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset setting.
		send_sep();
		send_hit(24'd5000, 24'sd3, 24'sd4, 24'sd0);
		send_sep();
		send_hit(24'd5000, 24'sd0, 24'sd0, 24'sd0);
		send_hit(24'd5000, 24'sd1, 24'sd2, 24'sd3);
		send_sep();
		send_hit(24'd5000, 24'sd7, -24'sd2, 24'sd9);
		send_hit(24'd5000, 24'sd7, -24'sd2, 24'sd9);
		send_sep();
		send_hit(24'hFFFFFF, 24'sd1, 24'sd1, 24'sd1);
		send_hit(24'd0, 24'sd2, 24'sd5, 24'sd1);
		send_sep();
		// Cosine of exactly minus one must land in bin zero (exactly one would land in the last bin).
		send_hit(24'd0, 24'sh7FFFFF, 24'sd0, 24'sd0);
		send_hit(24'd0, -24'sh800000, 24'sd0, 24'sd0);
		send_sep();
		send_hit(24'd2048, 24'sd100, 24'sd100, 24'sd0);
		send_hit(24'd0, 24'sd200, 24'sd200, 24'sd0);
		send_sep();
		send_hit(24'd1023, -24'sh800000, 24'sh7FFFFF, -24'sh800000);
		send_hit(24'd0, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
		send_sep();
		// Orthogonal step gives cosine zero.
		send_hit(24'd179199, 24'sd10, 24'sd0, 24'sd0);
		send_hit(24'd0, 24'sd10, 24'sd10, 24'sd0);
		send_sep();
		// More hits than the block keeps.
		for (int h = 0; h < MAX_HITS + 3; h++) begin
			send_hit($urandom, rand_coord(), rand_coord(), rand_coord());
		end
		send_sep();
		send_read(8'd0, 7'd99);
		send_read(8'd2, 7'd50);
		send_read(8'd255, 7'd127);
		send(CMD_UNUSED, '1, '1, '1, '1, '1, '1);
		wait_idle();

		// A zero bin width and zero bins in use reject every energy.
		write_reg(CFG_BIN_WIDTH, 24'd0);
		send_hit(24'd0, 24'sd1, 24'sd0, 24'sd0);
		send_hit(24'd0, 24'sd2, 24'sd1, 24'sd0);
		send_sep();
		wait_idle();
		write_reg(CFG_BIN_WIDTH, 24'd1);
		write_reg(CFG_BINS_USED, 24'd0);
		send_hit(24'd0, 24'sd1, 24'sd0, 24'sd0);
		send_hit(24'd0, 24'sd2, 24'sd1, 24'sd0);
		send_sep();
		wait_idle();

		// Random phases, each with its own setting and idling pattern.
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_BIN_WIDTH, widths[ph]);
			write_reg(CFG_BINS_USED, used_set[ph]);
			send_idle_pct = idle_set[ph];
			recv_stall_pct = stall_set[ph];
			target = sent + PHASE_ITEMS;
			if (ph == 0) begin
				// Long output hold while photons keep coming, so the input backs up.
				hold_reqs++;
				for (int k = 0; k < 12; k++) random_photon();
			end
			while (sent < target) begin
				random_item();
				if (ph == 1 && sent == target - 30) wait_idle();
			end
			wait_idle();
		end

		if (sb.errors == 0 && sb.wanted_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
